@@ src/apm_pkg.sv @@
// Shared types, constants and factory calibration tables of the autoranging power meter.
package apm_pkg;

  // Field and register widths
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;
  localparam int LIMIT_W      = 12;
  localparam int WSEL_W       = 3;
  localparam int RANGE_W      = 3;
  localparam int POWER_W      = 50;
  localparam int STATUS_W     = 2;

  // Calibration table geometry
  localparam int CAL_SAMPLE_W    = 12;
  localparam int FACTORY_MW_W    = 48;
  localparam int COEF_W          = 27;
  localparam int CAL_ENTRIES     = 16;
  localparam int CAL_IDX_W       = 4;
  localparam int WL_ENTRIES      = 7;
  localparam int FACTORY_MW_FRAC = 40;
  localparam int COEF_FRAC       = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_LIMIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH_SELECT = 3'd4;

  // Register reset values
  localparam logic [LIMIT_W-1:0] HIGH_THRESHOLD_RST = 12'd3850;
  localparam logic [LIMIT_W-1:0] LOW_THRESHOLD_RST  = 12'd150;
  localparam logic [LIMIT_W-1:0] OVER_LIMIT_RST     = 12'd4080;
  localparam logic [LIMIT_W-1:0] UNDER_LIMIT_RST    = 12'd30;
  localparam logic [WSEL_W-1:0]  WSEL_RST           = 3'd4;
  localparam logic [WSEL_W-1:0]  WSEL_LAST          = 3'd6;
  localparam logic [RANGE_W-1:0] RANGE_RST          = 3'd4;

  // Level status codes
  localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVER   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDER  = 2'd2;

  localparam logic [POWER_W-1:0] POWER_MAX = '1;

  // Factory calibration sample points
  typedef logic [CAL_ENTRIES-1:0][CAL_SAMPLE_W-1:0] sample_tab_t;
  localparam sample_tab_t CAL_SAMPLE = {
    12'd211,  12'd532,  12'd729,  12'd3089, 12'd784,  12'd3924, 12'd779,  12'd3889,
    12'd776,  12'd3865, 12'd809,  12'd3207, 12'd618,  12'd3646, 12'd799,  12'd3312
  };

  // Factory powers and coefficients as decimal mantissa times ten to the minus exponent
  typedef logic [CAL_ENTRIES-1:0][31:0] pow_mant_t;
  typedef logic [CAL_ENTRIES-1:0][3:0]  pow_exp_t;
  localparam pow_mant_t POW_MANT = {
    32'd202399997, 32'd511600001, 32'd630957629, 32'd316227779,
    32'd630957657, 32'd316227757, 32'd630957249, 32'd316227763,
    32'd630957261, 32'd316227749, 32'd630957261, 32'd251188636,
    32'd501187205, 32'd31622777,  32'd630957365, 32'd501187286
  };
  localparam pow_exp_t POW_EXP = {
    4'd14, 4'd14, 4'd14, 4'd13, 4'd13, 4'd12, 4'd12, 4'd11,
    4'd11, 4'd10, 4'd10, 4'd9,  4'd9,  4'd7,  4'd8,  4'd7
  };

  typedef logic [WL_ENTRIES-1:0][31:0] coef_mant_t;
  typedef logic [WL_ENTRIES-1:0][3:0]  coef_exp_t;
  localparam coef_mant_t COEF_MANT = {
    32'd10958333, 32'd105852938, 32'd1, 32'd998819292,
    32'd11150012, 32'd119675398, 32'd499930096
  };
  localparam coef_exp_t COEF_EXP = {4'd7, 4'd8, 4'd0, 4'd9, 4'd7, 4'd8, 4'd8};

  // Round mant * 10^-exp10 * 2^frac to nearest, half up; elaboration only
  function automatic logic [FACTORY_MW_W-1:0] fixed_from_decimal(
      input logic [31:0] mant, input logic [3:0] exp10, input int frac);
    logic [127:0] n;
    n = 128'(mant) << (frac + 1);
    for (int i = 0; i < 15; i++) begin
      if (i < int'(exp10)) n = n / 128'd10;
    end
    n = (n + 128'd1) >> 1;
    return n[FACTORY_MW_W-1:0];
  endfunction

  typedef logic [CAL_ENTRIES-1:0][FACTORY_MW_W-1:0] power_tab_t;
  typedef logic [WL_ENTRIES-1:0][COEF_W-1:0]        coef_tab_t;

  function automatic power_tab_t build_power_tab();
    power_tab_t t;
    for (int i = 0; i < CAL_ENTRIES; i++) begin
      t[i] = fixed_from_decimal(POW_MANT[i], POW_EXP[i], FACTORY_MW_FRAC);
    end
    return t;
  endfunction

  function automatic coef_tab_t build_coef_tab();
    coef_tab_t t;
    for (int i = 0; i < WL_ENTRIES; i++) begin
      t[i] = COEF_W'(fixed_from_decimal(COEF_MANT[i], COEF_EXP[i], COEF_FRAC));
    end
    return t;
  endfunction

  localparam power_tab_t FACTORY_MW = build_power_tab();
  localparam coef_tab_t  WL_COEF    = build_coef_tab();

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic prep;
    logic mul_lo;
    logic mul_hi;
    logic div_start;
    logic fix;
    logic scl_lo;
    logic scl_hi;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic measure;
    logic div_done;
  } dp_stat_t;

endpackage

@@ src/apm_sample_if.sv @@
// Sample channel: valid/ready handshake carrying one converter reading.
interface apm_sample_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

@@ src/apm_result_if.sv @@
// Result channel: valid/ready handshake carrying range, switch, power and status fields.
interface apm_result_if;
  logic                            valid;
  logic                            ready;
  logic [apm_pkg::RANGE_W-1:0]     range_index;
  logic                            aux_switch;
  logic                            discharge_request;
  logic                            measure_valid;
  logic [apm_pkg::POWER_W-1:0]     power_value;
  logic [apm_pkg::STATUS_W-1:0]    level_status;

  modport source (output valid, output range_index, output aux_switch,
                  output discharge_request, output measure_valid,
                  output power_value, output level_status, input ready);
  modport sink   (input valid, input range_index, input aux_switch,
                  input discharge_request, input measure_valid,
                  input power_value, input level_status, output ready);
endinterface

@@ src/autorange_power_meter_unit.sv @@
// Top level of the autoranging optical power meter.
// Each transferred ADC sample yields exactly one result. A sample outside the thresholds
// steps the gain range (down with a discharge request, up otherwise) and its result is
// loaded into the output register from the done state once that register is free. A
// sample that is measured runs operand selection, a two-step 12x48 multiply, a 15-step
// radix-16 divide, the sign fix and a two-step coefficient multiply before the done
// state loads its result. One sample is in work at a time; the next one is taken once
// the controller is back in idle, which it enters as the previous result is loaded
// into the output register, even before its transfer. Configuration writes take effect
// on the next sample and are meant for an idle block.
module autorange_power_meter_unit #(
  parameter int TOP_RANGE       = 6,
  parameter int SAMPLE_BITS     = 12,
  parameter int POWER_FRAC_BITS = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  apm_sample_if.sink                     in_stream,
  apm_result_if.source                   out_stream,
  input  logic                           cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  apm_pkg::ctl_cmd_t cmd;
  apm_pkg::dp_stat_t stat;
  logic [SAMPLE_BITS-1:0] sample;

  assign sample = in_stream.adc_sample;

  apm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  apm_dpath #(
    .TOP_RANGE       (TOP_RANGE),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .POWER_FRAC_BITS (POWER_FRAC_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .adc_sample        (sample),
    .cmd               (cmd),
    .stat              (stat),
    .range_index       (out_stream.range_index),
    .aux_switch        (out_stream.aux_switch),
    .discharge_request (out_stream.discharge_request),
    .measure_valid     (out_stream.measure_valid),
    .power_value       (out_stream.power_value),
    .level_status      (out_stream.level_status)
  );

endmodule

@@ src/apm_div.sv @@
// Radix-16 restoring divider: four quotient bits per cycle.
module apm_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int RADIX_BITS = 4;
  localparam int STEPS      = (NUM_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int WORK_W     = STEPS * RADIX_BITS;
  localparam int CNT_W      = $clog2(STEPS + 1);

  logic [WORK_W-1:0] work_r, work_nxt, work_step;
  logic [DEN_W-1:0]  rem_r, rem_nxt, rem_step;
  logic [DEN_W:0]    trial;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  // Four dependent shift-compare-subtract steps on the partial remainder
  always_comb begin
    rem_step  = rem_r;
    work_step = work_r;
    trial     = '0;
    for (int k = 0; k < RADIX_BITS; k++) begin
      trial     = {rem_step, work_step[WORK_W-1]};
      work_step = {work_step[WORK_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_step     = DEN_W'(trial - {1'b0, den});
        work_step[0] = 1'b1;
      end else begin
        rem_step = trial[DEN_W-1:0];
      end
    end
  end

  // Load on start, advance while busy, pulse done after the last step
  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      work_nxt = WORK_W'(num);
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      work_nxt = work_step;
      rem_nxt  = rem_step;
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
  end

  assign quo  = work_r[NUM_W-1:0];
  assign done = done_r;

endmodule

@@ src/apm_ctrl.sv @@
// Sequencing state machine: handshakes and datapath step commands.
module apm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  apm_pkg::dp_stat_t stat,
  output apm_pkg::ctl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREP     = 4'd1;
  localparam logic [3:0] S_MUL_LO   = 4'd2;
  localparam logic [3:0] S_MUL_HI   = 4'd3;
  localparam logic [3:0] S_DIV_GO   = 4'd4;
  localparam logic [3:0] S_DIV_WAIT = 4'd5;
  localparam logic [3:0] S_FIX      = 4'd6;
  localparam logic [3:0] S_SCL_LO   = 4'd7;
  localparam logic [3:0] S_SCL_HI   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.measure ? S_PREP : S_DONE;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_SCL_LO;
      end
      S_SCL_LO: begin
        cmd.scl_lo = 1'b1;
        state_nxt  = S_SCL_HI;
      end
      S_SCL_HI: begin
        cmd.scl_hi = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/apm_dpath.sv @@
// Datapath: configuration, range stepping, interpolation, scaling and result register.
module apm_dpath #(
  parameter int TOP_RANGE       = 6,
  parameter int SAMPLE_BITS     = 12,
  parameter int POWER_FRAC_BITS = 40
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]             adc_sample,
  input  apm_pkg::ctl_cmd_t                  cmd,
  output apm_pkg::dp_stat_t                  stat,
  output logic [apm_pkg::RANGE_W-1:0]        range_index,
  output logic                               aux_switch,
  output logic                               discharge_request,
  output logic                               measure_valid,
  output logic [apm_pkg::POWER_W-1:0]        power_value,
  output logic [apm_pkg::STATUS_W-1:0]       level_status
);

  localparam int CW      = (SAMPLE_BITS > apm_pkg::CAL_SAMPLE_W) ? SAMPLE_BITS
                                                                 : apm_pkg::CAL_SAMPLE_W;
  localparam int PW      = apm_pkg::FACTORY_MW_W;
  localparam int MW      = CW + PW;
  localparam int VW      = MW + 1;
  localparam int SPLIT   = PW / 2;
  localparam int PLO_W   = CW + SPLIT;
  localparam int PHI_W   = CW + PW - SPLIT;
  localparam int VSPLIT  = 32;
  localparam int VHI_W   = VW - VSPLIT;
  localparam int SLO_W   = VSPLIT + apm_pkg::COEF_W;
  localparam int SHI_W   = VHI_W + apm_pkg::COEF_W;
  localparam int AW      = VW + apm_pkg::COEF_W;
  localparam int SH      = apm_pkg::FACTORY_MW_FRAC + apm_pkg::COEF_FRAC - POWER_FRAC_BITS;
  localparam int IW      = apm_pkg::CAL_IDX_W;
  localparam logic [apm_pkg::RANGE_W-1:0] TOP_R = apm_pkg::RANGE_W'(TOP_RANGE);
  localparam logic [IW-1:0] TOP_B0 = IW'((2 * TOP_RANGE) % apm_pkg::CAL_ENTRIES);
  localparam logic [IW-1:0] TOP_B1 = TOP_B0 + IW'(1);
  localparam logic [IW-1:0] TOP_B2 = TOP_B0 + IW'(2);
  localparam logic [IW-1:0] TOP_B3 = TOP_B0 + IW'(3);

  // Configuration registers
  logic [apm_pkg::LIMIT_W-1:0] high_thr_r, low_thr_r, over_lim_r, under_lim_r;
  logic [apm_pkg::WSEL_W-1:0]  wsel_r;

  // Per-sample working registers
  logic [apm_pkg::RANGE_W-1:0]  range_r, range_nxt;
  logic [SAMPLE_BITS-1:0]       sample_r;
  logic                         dis_r, meas_r;
  logic [apm_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [PW-1:0]                p0_r, mdp_r;
  logic [CW-1:0]                mds_r;
  logic [apm_pkg::CAL_SAMPLE_W-1:0] mdy_r;
  logic                         neg_r;
  logic [MW-1:0]                prod_r;
  logic [VW-1:0]                v_r;
  logic                         zero_r;
  logic [AW-1:0]                acc_r;

  // Result register
  logic [apm_pkg::RANGE_W-1:0]  range_out_r;
  logic                         aux_out_r, dis_out_r, meas_out_r;
  logic [apm_pkg::POWER_W-1:0]  power_out_r;
  logic [apm_pkg::STATUS_W-1:0] status_out_r;

  // Decision signals on the incoming sample
  logic [CW-1:0] s_in, s_cur;
  logic          step_dn, step_up, top_now;

  // Interpolation operand selection
  logic [IW-1:0]                    ia, ib;
  logic [apm_pkg::CAL_SAMPLE_W-1:0] xa, xb;
  logic [CW-1:0]                    xa_e;
  logic [PW-1:0]                    pa, pb;
  logic [CW-1:0]                    mds;
  logic [apm_pkg::CAL_SAMPLE_W-1:0] mdy;
  logic [PW-1:0]                    mdp;
  logic                             ds_neg, dy_neg, dp_neg;

  logic [PLO_W-1:0] lo_pp;
  logic [PHI_W-1:0] hi_pp;
  logic [MW-1:0]    quo, q_eff;
  logic             div_done;
  logic [VW-1:0]    v_calc;
  logic             zero_calc;
  logic [apm_pkg::WSEL_W-1:0] wsel_eff;
  logic [apm_pkg::COEF_W-1:0] coef;
  logic [SLO_W-1:0] slo_pp;
  logic [SHI_W-1:0] shi_pp;
  logic [AW-1:0]    scaled;
  logic [apm_pkg::POWER_W-1:0] power_calc;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r  <= apm_pkg::HIGH_THRESHOLD_RST;
      low_thr_r   <= apm_pkg::LOW_THRESHOLD_RST;
      over_lim_r  <= apm_pkg::OVER_LIMIT_RST;
      under_lim_r <= apm_pkg::UNDER_LIMIT_RST;
      wsel_r      <= apm_pkg::WSEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apm_pkg::REG_HIGH_THRESHOLD:    high_thr_r  <= cfg_wdata;
        apm_pkg::REG_LOW_THRESHOLD:     low_thr_r   <= cfg_wdata;
        apm_pkg::REG_OVER_LIMIT:        over_lim_r  <= cfg_wdata;
        apm_pkg::REG_UNDER_LIMIT:       under_lim_r <= cfg_wdata;
        apm_pkg::REG_WAVELENGTH_SELECT: wsel_r      <= cfg_wdata[apm_pkg::WSEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Range decision for the sample on the input channel
  always_comb begin
    s_in    = CW'(adc_sample);
    top_now = (range_r >= TOP_R);
    step_dn = (s_in > CW'(high_thr_r)) && (range_r != '0);
    step_up = !step_dn && (s_in < CW'(low_thr_r)) && (range_r < TOP_R);
    if (step_dn) range_nxt = range_r - apm_pkg::RANGE_W'(1);
    else if (step_up) range_nxt = range_r + apm_pkg::RANGE_W'(1);
    else range_nxt = range_r;
    if (top_now && s_in < CW'(under_lim_r)) status_nxt = apm_pkg::STATUS_UNDER;
    else if (range_r == '0 && s_in > CW'(over_lim_r)) status_nxt = apm_pkg::STATUS_OVER;
    else status_nxt = apm_pkg::STATUS_NORMAL;
  end

  assign stat.measure  = !step_dn && !step_up;
  assign stat.div_done = div_done;

  // Latch the transferred sample and step the range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= apm_pkg::RANGE_RST;
    end else if (cmd.accept) begin
      range_r <= range_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= adc_sample;
      dis_r    <= step_dn;
      meas_r   <= stat.measure;
      status_r <= stat.measure ? status_nxt : apm_pkg::STATUS_NORMAL;
    end
  end

  // Pick the calibration segment and form the difference magnitudes
  always_comb begin
    s_cur = CW'(sample_r);
    if (range_r >= TOP_R) begin
      if (s_cur >= CW'(apm_pkg::CAL_SAMPLE[TOP_B0])) begin
        ia = TOP_B0;
        ib = TOP_B1;
      end else if (s_cur <= CW'(apm_pkg::CAL_SAMPLE[TOP_B3])) begin
        ia = TOP_B2;
        ib = TOP_B3;
      end else begin
        ia = TOP_B3;
        ib = TOP_B0;
      end
    end else begin
      ia = {range_r, 1'b0};
      ib = {range_r, 1'b1};
    end
    xa   = apm_pkg::CAL_SAMPLE[ia];
    xb   = apm_pkg::CAL_SAMPLE[ib];
    pa   = apm_pkg::FACTORY_MW[ia];
    pb   = apm_pkg::FACTORY_MW[ib];
    xa_e = CW'(xa);
    ds_neg = (s_cur < xa_e);
    mds    = ds_neg ? (xa_e - s_cur) : (s_cur - xa_e);
    dy_neg = (xb < xa);
    mdy    = dy_neg ? (xa - xb) : (xb - xa);
    dp_neg = (pb < pa);
    mdp    = dp_neg ? (pa - pb) : (pb - pa);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      p0_r  <= pa;
      mds_r <= mds;
      mdy_r <= mdy;
      mdp_r <= mdp;
      neg_r <= ds_neg ^ dy_neg ^ dp_neg;
    end
  end

  // Form |ds| * |dp| in two partial products
  assign lo_pp = PLO_W'(mds_r) * PLO_W'(mdp_r[SPLIT-1:0]);
  assign hi_pp = PHI_W'(mds_r) * PHI_W'(mdp_r[PW-1:SPLIT]);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) prod_r <= MW'(lo_pp);
    else if (cmd.mul_hi) prod_r <= prod_r + (MW'(hi_pp) << SPLIT);
  end

  apm_div #(
    .NUM_W (MW),
    .DEN_W (apm_pkg::CAL_SAMPLE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (mdy_r),
    .quo   (quo),
    .done  (div_done)
  );

  // Apply the slope term with its sign; drop it for a flat segment
  always_comb begin
    q_eff     = (mdy_r == '0) ? '0 : quo;
    zero_calc = 1'b0;
    v_calc    = VW'(p0_r);
    if (neg_r) begin
      if (q_eff >= MW'(p0_r)) zero_calc = 1'b1;
      else v_calc = VW'(MW'(p0_r) - q_eff);
    end else begin
      v_calc = VW'(p0_r) + VW'(q_eff);
    end
    if (v_calc == '0) zero_calc = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      v_r    <= v_calc;
      zero_r <= zero_calc;
    end
  end

  // Scale by the wavelength coefficient in two partial products
  assign wsel_eff = (wsel_r > apm_pkg::WSEL_LAST) ? apm_pkg::WSEL_LAST : wsel_r;
  assign coef     = apm_pkg::WL_COEF[wsel_eff];
  assign slo_pp   = SLO_W'(v_r[VSPLIT-1:0]) * SLO_W'(coef);
  assign shi_pp   = SHI_W'(v_r[VW-1:VSPLIT]) * SHI_W'(coef);

  always_ff @(posedge clk) begin
    if (cmd.scl_lo) acc_r <= AW'(slo_pp);
    else if (cmd.scl_hi) acc_r <= acc_r + (AW'(shi_pp) << VSPLIT);
  end

  // Drop fraction bits and saturate
  assign scaled     = acc_r >> SH;
  assign power_calc = (scaled > AW'(apm_pkg::POWER_MAX)) ? apm_pkg::POWER_MAX
                                                          : scaled[apm_pkg::POWER_W-1:0];

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      range_out_r  <= range_r;
      aux_out_r    <= (range_r == apm_pkg::RANGE_W'(1));
      dis_out_r    <= dis_r;
      meas_out_r   <= meas_r;
      power_out_r  <= (meas_r && !zero_r) ? power_calc : '0;
      status_out_r <= status_r;
    end
  end

  assign range_index       = range_out_r;
  assign aux_switch        = aux_out_r;
  assign discharge_request = dis_out_r;
  assign measure_valid     = meas_out_r;
  assign power_value       = power_out_r;
  assign level_status      = status_out_r;

endmodule

@@ src/apm_checker.sv @@
// Port-level checks of the power meter, attached to the top level by bind.
module apm_checker #(
  parameter int TOP_RANGE = 6
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [apm_pkg::RANGE_W-1:0]   range_index,
  input logic                          aux_switch,
  input logic                          discharge_request,
  input logic                          measure_valid,
  input logic [apm_pkg::POWER_W-1:0]   power_value,
  input logic [apm_pkg::STATUS_W-1:0]  level_status
);

  // One sample in work: no second transfer right after one
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

  // A pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  // Aux line follows range one
  a_aux: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (aux_switch == (range_index == apm_pkg::RANGE_W'(1))))
    else $error("aux switch does not match range");

  // A range step carries no measurement
  a_step_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !measure_valid) |->
      (power_value == '0 && level_status == apm_pkg::STATUS_NORMAL))
    else $error("power or status set without a measurement");

  // Level flags only at the range ends, and never a discharge with a measurement
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((level_status != apm_pkg::STATUS_OVER || range_index == '0) &&
       (level_status != apm_pkg::STATUS_UNDER ||
        range_index >= apm_pkg::RANGE_W'(TOP_RANGE)) &&
       !(discharge_request && measure_valid)))
    else $error("level status or discharge inconsistent with range");

endmodule

bind autorange_power_meter_unit apm_checker #(.TOP_RANGE(TOP_RANGE)) u_apm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_stream.valid),
  .in_ready          (in_stream.ready),
  .out_valid         (out_stream.valid),
  .out_ready         (out_stream.ready),
  .range_index       (out_stream.range_index),
  .aux_switch        (out_stream.aux_switch),
  .discharge_request (out_stream.discharge_request),
  .measure_valid     (out_stream.measure_valid),
  .power_value       (out_stream.power_value),
  .level_status      (out_stream.level_status)
);
